// File: hw/rtl/srsd_pkg.sv
// ----------------------------------------------------------------------------
// srsd_pkg - shared types and constants of the snapshot record decoder
// Result layout, field and status codes, header and record tables, CRC step.
// ----------------------------------------------------------------------------
package srsd_pkg;

   localparam int HDR_BYTES      = 40;
   localparam int REC_BYTES      = 24;
   localparam int CRC_SPAN       = 32;
   localparam int STORED_CRC_END = 35;
   localparam int RESULT_DEPTH   = 4;
   localparam int RESULT_PTR_W   = $clog2(RESULT_DEPTH);
   localparam int RESULT_CNT_W   = $clog2(RESULT_DEPTH + 1);

   localparam logic [31:0] MAGIC_WORD = 32'h3153_544D;
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic [4:0] FC_MAGIC        = 5'd0;
   localparam logic [4:0] FC_VERSION      = 5'd1;
   localparam logic [4:0] FC_FLAGS        = 5'd2;
   localparam logic [4:0] FC_RECORD_COUNT = 5'd3;
   localparam logic [4:0] FC_CUR_USED     = 5'd4;
   localparam logic [4:0] FC_PEAK_USED    = 5'd5;
   localparam logic [4:0] FC_TOTAL_ALLOCS = 5'd6;
   localparam logic [4:0] FC_TOTAL_FREES  = 5'd7;
   localparam logic [4:0] FC_HDR_SEQUENCE = 5'd8;
   localparam logic [4:0] FC_REC_PTR      = 5'd9;
   localparam logic [4:0] FC_REC_SIZE     = 5'd10;
   localparam logic [4:0] FC_REC_FILE     = 5'd11;
   localparam logic [4:0] FC_REC_LINE     = 5'd12;
   localparam logic [4:0] FC_REC_STATE    = 5'd13;
   localparam logic [4:0] FC_REC_PAD      = 5'd14;
   localparam logic [4:0] FC_REC_SEQUENCE = 5'd15;
   localparam logic [4:0] FC_STATUS       = 5'd16;

   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_SHORT_HEADER  = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC     = 3'd2;
   localparam logic [2:0] ST_BAD_VERSION   = 3'd3;
   localparam logic [2:0] ST_SHORT_RECORDS = 3'd4;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'b01,
      PHASE_ACTIVE = 2'b10
   } phase_type;

   typedef struct packed {
      logic        command;
      logic [31:0] payload_length;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic [4:0]  field_code;
      logic [63:0] field_value;
      logic [27:0] record_index;
      logic [2:0]  status_code;
      logic        crc_match;
      logic        end_of_payload;
      logic        last_of_item;
   } result_type;

   // up to two results written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
      logic [3:0] len;
   } field_slot_type;

   function automatic field_slot_type hdr_lookup(logic [5:0] off);
      field_slot_type s;
      s = '0;
      case (off)
         6'd3:  s = '{1'b1, FC_MAGIC,        4'd4};
         6'd5:  s = '{1'b1, FC_VERSION,      4'd2};
         6'd7:  s = '{1'b1, FC_FLAGS,        4'd2};
         6'd11: s = '{1'b1, FC_RECORD_COUNT, 4'd4};
         6'd15: s = '{1'b1, FC_CUR_USED,     4'd4};
         6'd19: s = '{1'b1, FC_PEAK_USED,    4'd4};
         6'd23: s = '{1'b1, FC_TOTAL_ALLOCS, 4'd4};
         6'd27: s = '{1'b1, FC_TOTAL_FREES,  4'd4};
         6'd31: s = '{1'b1, FC_HDR_SEQUENCE, 4'd4};
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic field_slot_type rec_lookup(logic [4:0] pos);
      field_slot_type s;
      s = '0;
      case (pos)
         5'd7:  s = '{1'b1, FC_REC_PTR,      4'd8};
         5'd11: s = '{1'b1, FC_REC_SIZE,     4'd4};
         5'd15: s = '{1'b1, FC_REC_FILE,     4'd4};
         5'd17: s = '{1'b1, FC_REC_LINE,     4'd2};
         5'd18: s = '{1'b1, FC_REC_STATE,    4'd1};
         5'd19: s = '{1'b1, FC_REC_PAD,      4'd1};
         5'd23: s = '{1'b1, FC_REC_SEQUENCE, 4'd4};
         default: s = '0;
      endcase
      return s;
   endfunction

   // newest byte sits at the top of the assembly word
   function automatic logic [63:0] take_field(logic [63:0] fa, logic [3:0] len);
      logic [63:0] v;
      case (len)
         4'd1:    v = {56'b0, fa[63:56]};
         4'd2:    v = {48'b0, fa[63:48]};
         4'd4:    v = {32'b0, fa[63:32]};
         default: v = fa;
      endcase
      return v;
   endfunction

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'b0, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      end
      return x;
   endfunction

endpackage

// File: hw/rtl/srsd_if.sv
// ----------------------------------------------------------------------------
// srsd_if - request and response channels of the snapshot record decoder
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface srsd_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] payload_length;
   logic [7:0]  data_byte;

   modport source (output valid, output command, output payload_length,
                   output data_byte, input ready);
   modport sink   (input valid, input command, input payload_length,
                   input data_byte, output ready);
endinterface

interface srsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  field_code;
   logic [63:0] field_value;
   logic [27:0] record_index;
   logic [2:0]  status_code;
   logic        crc_match;
   logic        end_of_payload;
   logic        last_of_item;

   modport source (output valid, output field_code, output field_value,
                   output record_index, output status_code, output crc_match,
                   output end_of_payload, output last_of_item, input ready);
   modport sink   (input valid, input field_code, input field_value,
                   input record_index, input status_code, input crc_match,
                   input end_of_payload, input last_of_item, output ready);
endinterface

// File: hw/rtl/srsd_decoder.sv
// ----------------------------------------------------------------------------
// srsd_decoder - input register and per-byte decode
// Registers one request, then decodes it against the payload state and
// hands zero, one or two results to the result queue.
// ----------------------------------------------------------------------------
module srsd_decoder
   import srsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   srsd_req_if.sink       req_chan,
   input  logic           queue_room,
   output push_type       push
);

   logic        in_valid_ff, in_valid_in;
   item_type    item_ff, item_in;

   phase_type   phase_ff, phase_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] expected_ff, expected_in;
   logic [63:0] assembly_ff, assembly_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] stored_ff, stored_in;
   logic [31:0] declared_ff, declared_in;
   logic [27:0] rec_count_ff, rec_count_in;
   logic [4:0]  rec_pos_ff, rec_pos_in;

   logic           accept, process;
   logic [7:0]     b;
   logic [31:0]    off, off_next;
   logic [63:0]    value;
   logic [37:0]    need;
   field_slot_type slot;
   logic           failed;
   logic [2:0]     fail_code;
   logic           field_hit, final_hit;
   result_type     field_res, final_res, fail_res;

   assign req_chan.ready = !in_valid_ff || queue_room;
   assign accept  = req_chan.valid && req_chan.ready;
   assign process = in_valid_ff && queue_room;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         item_in     = '{req_chan.command, req_chan.payload_length, req_chan.data_byte};
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      expected_in  = expected_ff;
      assembly_in  = assembly_ff;
      crc_in       = crc_ff;
      stored_in    = stored_ff;
      declared_in  = declared_ff;
      rec_count_in = rec_count_ff;
      rec_pos_in   = rec_pos_ff;
      push         = '0;

      b         = item_ff.data_byte;
      off       = offset_ff;
      off_next  = offset_ff + 32'd1;
      value     = '0;
      need      = '0;
      slot      = '0;
      failed    = 1'b0;
      fail_code = ST_OK;
      field_hit = 1'b0;
      final_hit = 1'b0;
      field_res = '0;
      final_res = '0;
      fail_res  = '0;

      if (process) begin
         if (item_ff.command == CMD_START) begin
            phase_in     = PHASE_ACTIVE;
            offset_in    = '0;
            expected_in  = item_ff.payload_length;
            assembly_in  = '0;
            crc_in       = CRC_PRESET;
            stored_in    = '0;
            declared_in  = '0;
            rec_count_in = '0;
            rec_pos_in   = '0;
            if (item_ff.payload_length < 32'(HDR_BYTES)) begin
               failed    = 1'b1;
               fail_code = ST_SHORT_HEADER;
            end
         end else if (phase_ff == PHASE_ACTIVE) begin
            // CRC skips the stored checksum and the unused word
            if (off < 32'(CRC_SPAN) || off >= 32'(HDR_BYTES)) begin
               crc_in = crc_byte(crc_ff, b);
            end
            assembly_in = {b, assembly_ff[63:8]};

            if (off < 32'(HDR_BYTES)) begin
               slot  = hdr_lookup(off[5:0]);
               value = take_field(assembly_in, slot.len);
               need  = 38'(HDR_BYTES) + ({6'b0, value[31:0]} << 4)
                       + ({6'b0, value[31:0]} << 3);
               if (slot.hit) begin
                  if (slot.code == FC_MAGIC && value != {32'b0, MAGIC_WORD}) begin
                     failed    = 1'b1;
                     fail_code = ST_BAD_MAGIC;
                  end else if (slot.code == FC_VERSION && value != 64'd1) begin
                     failed    = 1'b1;
                     fail_code = ST_BAD_VERSION;
                  end else if (slot.code == FC_RECORD_COUNT
                               && need > {6'b0, expected_ff}) begin
                     failed    = 1'b1;
                     fail_code = ST_SHORT_RECORDS;
                  end else begin
                     field_hit = 1'b1;
                  end
                  if (slot.code == FC_RECORD_COUNT) begin
                     declared_in = value[31:0];
                  end
               end
               if (off == 32'(STORED_CRC_END)) begin
                  stored_in = assembly_in[63:32];
               end
            end else if ({4'b0, rec_count_ff} < declared_ff) begin
               slot      = rec_lookup(rec_pos_ff);
               value     = take_field(assembly_in, slot.len);
               field_hit = slot.hit;
               if (rec_pos_ff == 5'(REC_BYTES - 1)) begin
                  rec_count_in = rec_count_ff + 28'd1;
                  rec_pos_in   = '0;
               end else begin
                  rec_pos_in = rec_pos_ff + 5'd1;
               end
            end

            if (!failed) begin
               offset_in = off_next;
               if (off_next == expected_ff) begin
                  final_hit = 1'b1;
                  phase_in  = PHASE_IDLE;
               end
            end
         end

         if (failed) begin
            phase_in = PHASE_IDLE;
         end

         field_res.field_code   = slot.code;
         field_res.field_value  = value;
         field_res.record_index = (off < 32'(HDR_BYTES)) ? 28'd0 : rec_count_ff;

         final_res.field_code     = FC_STATUS;
         final_res.status_code    = ST_OK;
         final_res.crc_match      = ((crc_in ^ CRC_PRESET) == stored_in);
         final_res.end_of_payload = 1'b1;
         final_res.last_of_item   = 1'b1;

         fail_res.field_code     = FC_STATUS;
         fail_res.status_code    = fail_code;
         fail_res.end_of_payload = 1'b1;
         fail_res.last_of_item   = 1'b1;

         if (failed) begin
            push.count = 2'd1;
            push.first = fail_res;
         end else if (field_hit && final_hit) begin
            push.count  = 2'd2;
            push.first  = field_res;
            push.second = final_res;
         end else if (field_hit) begin
            push.count              = 2'd1;
            push.first              = field_res;
            push.first.last_of_item = 1'b1;
         end else if (final_hit) begin
            push.count = 2'd1;
            push.first = final_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PHASE_IDLE;
         offset_ff    <= '0;
         expected_ff  <= '0;
         assembly_ff  <= '0;
         crc_ff       <= CRC_PRESET;
         stored_ff    <= '0;
         declared_ff  <= '0;
         rec_count_ff <= '0;
         rec_pos_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         expected_ff  <= expected_in;
         assembly_ff  <= assembly_in;
         crc_ff       <= crc_in;
         stored_ff    <= stored_in;
         declared_ff  <= declared_in;
         rec_count_ff <= rec_count_in;
         rec_pos_ff   <= rec_pos_in;
      end
   end

endmodule

// File: hw/rtl/srsd_result_queue.sv
// ----------------------------------------------------------------------------
// srsd_result_queue - small result queue in front of the response channel
// Takes up to two results a cycle from the decoder, sends one per transfer.
// ----------------------------------------------------------------------------
module srsd_result_queue
   import srsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  push_type       push,
   output logic           queue_room,
   srsd_rsp_if.source     rsp_chan
);

   result_type                entries_ff [RESULT_DEPTH];
   logic [RESULT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RESULT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RESULT_CNT_W-1:0]   count_ff, count_in;
   logic                      pop;
   result_type                head;

   // room for the worst case of two results from one item
   assign queue_room = (count_ff <= RESULT_CNT_W'(RESULT_DEPTH - 2));

   assign head           = entries_ff[rd_ptr_ff];
   assign rsp_chan.valid = (count_ff != '0);
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.field_code     = head.field_code;
   assign rsp_chan.field_value    = head.field_value;
   assign rsp_chan.record_index   = head.record_index;
   assign rsp_chan.status_code    = head.status_code;
   assign rsp_chan.crc_match      = head.crc_match;
   assign rsp_chan.end_of_payload = head.end_of_payload;
   assign rsp_chan.last_of_item   = head.last_of_item;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RESULT_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RESULT_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RESULT_CNT_W'(push.count) - RESULT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + RESULT_PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RESULT_CNT_W'(RESULT_DEPTH))
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> queue_room)
      else $error("results pushed without room");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two results from one item");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      count_ff == RESULT_CNT_W'(RESULT_DEPTH)
      |-> wr_ptr_ff == rd_ptr_ff)
      else $error("full queue with pointers apart");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0)
      else $error("queue not empty after reset");

endmodule

// File: hw/rtl/snapshot_record_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// snapshot_record_stream_decoder_core - snapshot payload decoder, top level
// Decodes a byte stream of header and records into field results and a
// final status with CRC agreement.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per transfer: a start command with the payload
//   length, or one data byte. rsp_chan carries one result per transfer:
//   a header or record field as its last byte arrives, or a status that
//   closes the payload (end_of_payload) with error code or CRC agreement.
//   last_of_item marks the last result caused by a request.
//   A request is held in the input register, then decoded into the result
//   queue, from which its results are offered on rsp_chan.
//   Throughput: one request per cycle. The decode stage needs room for two
//   results in the four-entry result queue, so a request that makes two
//   results, or a receiver that stalls, holds req_chan.ready low once the
//   queue has more than two results waiting.
//   Reset (synchronous, active high) empties the queue and returns the
//   decoder to idle; data bytes before a start give no result.
//   A start command in mid-payload silently abandons the open payload.
// ----------------------------------------------------------------------------
module snapshot_record_stream_decoder_core
   import srsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   srsd_req_if.sink    req_chan,
   srsd_rsp_if.source  rsp_chan
);

   push_type push;
   logic     queue_room;

   srsd_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_room (queue_room),
      .push       (push)
   );

   srsd_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: dv/snapshot_record_stream_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// snapshot_record_stream_decoder_core_tb - self-checking bench of the decoder
// Feeds start and byte transfers (directed corner cases, then random payloads
// built with a correct or corrupted CRC), predicts every field and status
// result with a local decoder model and compares each result transfer.
// ----------------------------------------------------------------------------
module snapshot_record_stream_decoder_core_tb
   import srsd_pkg::*;
();

   localparam int RANDOM_ITEMS  = 300;
   localparam int QUIET_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PRINT_LIMIT   = 40;

   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srsd_req_if req_chan ();
   srsd_rsp_if rsp_chan ();

   snapshot_record_stream_decoder_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // decoder model state
   phase_type   dec_phase;
   logic [31:0] dec_offset;
   logic [31:0] dec_length;
   logic [63:0] dec_assembly;
   logic [31:0] dec_crc;
   logic [31:0] dec_stored;
   logic [31:0] dec_declared;
   logic [27:0] dec_record;

   result_type  pending_results[$];
   logic [7:0]  frame[$];

   int burst_left;
   int request_count;
   int decoded_items;
   int result_count       = 0;
   int mismatch_count     = 0;
   int ok_crc_match       = 0;
   int ok_crc_miss        = 0;
   int error_status_count = 0;
   int quiet_cycles       = 0;

   function automatic void clear_decoder();
      dec_phase    = PHASE_IDLE;
      dec_offset   = '0;
      dec_length   = '0;
      dec_assembly = '0;
      dec_crc      = CRC_PRESET;
      dec_stored   = '0;
      dec_declared = '0;
      dec_record   = '0;
   endfunction

   // bit-serial reflected CRC, LSB of the byte first
   function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ b[k]) r = {1'b0, r[31:1]} ^ CRC_POLY;
         else r = {1'b0, r[31:1]};
      end
      return r;
   endfunction

   function automatic int header_slot(input logic [31:0] off, output logic [4:0] code);
      int len;
      len  = 4;
      code = FC_MAGIC;
      case (off)
         32'd3:  code = FC_MAGIC;
         32'd5:  begin
            code = FC_VERSION;
            len  = 2;
         end
         32'd7:  begin
            code = FC_FLAGS;
            len  = 2;
         end
         32'd11: code = FC_RECORD_COUNT;
         32'd15: code = FC_CUR_USED;
         32'd19: code = FC_PEAK_USED;
         32'd23: code = FC_TOTAL_ALLOCS;
         32'd27: code = FC_TOTAL_FREES;
         32'd31: code = FC_HDR_SEQUENCE;
         default: len = 0;
      endcase
      return len;
   endfunction

   function automatic int record_slot(input logic [31:0] pos, output logic [4:0] code);
      int len;
      len  = 4;
      code = FC_REC_PTR;
      case (pos)
         32'd7:  begin
            code = FC_REC_PTR;
            len  = 8;
         end
         32'd11: code = FC_REC_SIZE;
         32'd15: code = FC_REC_FILE;
         32'd17: begin
            code = FC_REC_LINE;
            len  = 2;
         end
         32'd18: begin
            code = FC_REC_STATE;
            len  = 1;
         end
         32'd19: begin
            code = FC_REC_PAD;
            len  = 1;
         end
         32'd23: code = FC_REC_SEQUENCE;
         default: len = 0;
      endcase
      return len;
   endfunction

   function automatic result_type field_result(logic [4:0] code, logic [63:0] value,
                                               logic [27:0] idx);
      result_type r;
      r = '0;
      r.field_code   = code;
      r.field_value  = value;
      r.record_index = idx;
      return r;
   endfunction

   function automatic result_type status_result(logic [2:0] st, logic match);
      result_type r;
      r = '0;
      r.field_code     = FC_STATUS;
      r.status_code    = st;
      r.crc_match      = match;
      r.end_of_payload = 1'b1;
      return r;
   endfunction

   // returns 1 when the item is not simply ignored
   function automatic bit decode_item(item_type it);
      result_type  found[$];
      result_type  tail;
      logic [31:0] off;
      logic [31:0] pos;
      logic [63:0] value;
      logic [4:0]  code;
      logic [2:0]  fault;
      int          len;
      bit          used;
      used  = 1'b1;
      fault = ST_OK;
      if (it.command == CMD_START) begin
         clear_decoder();
         dec_length = it.payload_length;
         if (dec_length < HDR_BYTES) found.push_back(status_result(ST_SHORT_HEADER, 1'b0));
         else dec_phase = PHASE_ACTIVE;
      end else if (dec_phase != PHASE_ACTIVE) begin
         used = 1'b0;
      end else begin
         off = dec_offset;
         if (off < CRC_SPAN || off >= HDR_BYTES) dec_crc = crc_step(dec_crc, it.data_byte);
         dec_assembly = {it.data_byte, dec_assembly[63:8]};
         if (off < HDR_BYTES) begin
            len = header_slot(off, code);
            if (len != 0) begin
               value = dec_assembly >> (64 - 8 * len);
               if (code == FC_MAGIC && value != {32'b0, MAGIC_WORD}) begin
                  fault = ST_BAD_MAGIC;
               end else if (code == FC_VERSION && value != 64'd1) begin
                  fault = ST_BAD_VERSION;
               end else if (code == FC_RECORD_COUNT) begin
                  dec_declared = value[31:0];
                  // 64-bit sum, a huge count must not wrap
                  if (64'(HDR_BYTES) + value * 64'(REC_BYTES) > 64'(dec_length))
                     fault = ST_SHORT_RECORDS;
               end
               if (fault == ST_OK) found.push_back(field_result(code, value, '0));
            end
            if (off == STORED_CRC_END) dec_stored = dec_assembly[63:32];
         end else if ({4'b0, dec_record} < dec_declared) begin
            pos = (off - HDR_BYTES) % REC_BYTES;
            len = record_slot(pos, code);
            if (len != 0)
               found.push_back(field_result(code, dec_assembly >> (64 - 8 * len), dec_record));
            if (pos == REC_BYTES - 1) dec_record = dec_record + 1'b1;
         end
         if (fault != ST_OK) begin
            found.push_back(status_result(fault, 1'b0));
            dec_phase = PHASE_IDLE;
         end else begin
            dec_offset = off + 1;
            if (dec_offset == dec_length) begin
               found.push_back(status_result(ST_OK, ~dec_crc == dec_stored));
               dec_phase = PHASE_IDLE;
            end
         end
      end
      if (found.size() > 0) begin
         tail = found.pop_back();
         tail.last_of_item = 1'b1;
         found.push_back(tail);
         foreach (found[k]) pending_results.push_back(found[k]);
      end
      return used;
   endfunction

   task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch: %s on result %0d, got 0x%0h, wanted 0x%0h",
                  what, result_count, got, want);
      mismatch_count++;
   endtask

   // receiver: ready pattern switches between open, light, heavy and bursty stalls
   initial begin
      rx_mode_type rx_mode;
      int          mode_left;
      int          hold;
      bit          level;
      rsp_chan.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      hold      = 0;
      level     = 1'b1;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(64, 256);
         end
         mode_left--;
         case (rx_mode)
            RX_OPEN:  rsp_chan.ready <= 1'b1;
            RX_LIGHT: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: begin
               if (hold == 0) begin
                  level = !level;
                  hold  = level ? $urandom_range(1, 6) : $urandom_range(1, 12);
               end
               hold--;
               rsp_chan.ready <= level;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.field_code     = rsp_chan.field_code;
         got.field_value    = rsp_chan.field_value;
         got.record_index   = rsp_chan.record_index;
         got.status_code    = rsp_chan.status_code;
         got.crc_match      = rsp_chan.crc_match;
         got.end_of_payload = rsp_chan.end_of_payload;
         got.last_of_item   = rsp_chan.last_of_item;
         if (pending_results.size() == 0) begin
            note_mismatch("result with nothing pending, field_code", got.field_code, '0);
         end else begin
            want = pending_results.pop_front();
            if (got.field_code !== want.field_code)
               note_mismatch("field_code", got.field_code, want.field_code);
            if (got.field_value !== want.field_value)
               note_mismatch("field_value", got.field_value, want.field_value);
            if (got.record_index !== want.record_index)
               note_mismatch("record_index", got.record_index, want.record_index);
            if (got.status_code !== want.status_code)
               note_mismatch("status_code", got.status_code, want.status_code);
            if (got.crc_match !== want.crc_match)
               note_mismatch("crc_match", got.crc_match, want.crc_match);
            if (got.end_of_payload !== want.end_of_payload)
               note_mismatch("end_of_payload", got.end_of_payload, want.end_of_payload);
            if (got.last_of_item !== want.last_of_item)
               note_mismatch("last_of_item", got.last_of_item, want.last_of_item);
            if (want.end_of_payload) begin
               if (want.status_code != ST_OK) error_status_count++;
               else if (want.crc_match) ok_crc_match++;
               else ok_crc_miss++;
            end
         end
         result_count++;
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one request transfer; the sender runs in bursts with random gaps
   task automatic offer_item(logic cmd, logic [31:0] len, logic [7:0] data);
      item_type it;
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) < 7) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      it.command        = cmd;
      it.payload_length = len;
      it.data_byte      = data;
      req_chan.valid          <= 1'b1;
      req_chan.command        <= cmd;
      req_chan.payload_length <= len;
      req_chan.data_byte      <= data;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      request_count++;
      if (decode_item(it)) decoded_items++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // payload image: header, records, trailing bytes, CRC in bytes 32..35
   function automatic void build_frame(int records, int trail, bit crc_good);
      logic [31:0] crc;
      frame.delete();
      for (int k = 0; k < 4; k++) frame.push_back(MAGIC_WORD[8 * k +: 8]);
      frame.push_back(8'h01);
      frame.push_back(8'h00);
      repeat (2) frame.push_back(rand_byte());
      for (int k = 0; k < 4; k++) frame.push_back(8'(records >> (8 * k)));
      while (frame.size() < HDR_BYTES) frame.push_back(rand_byte());
      repeat (records * REC_BYTES + trail) frame.push_back(rand_byte());
      crc = CRC_PRESET;
      foreach (frame[k])
         if (k < CRC_SPAN || k >= HDR_BYTES) crc = crc_step(crc, frame[k]);
      crc = ~crc;
      if (!crc_good) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      for (int k = 0; k < 4; k++) frame[CRC_SPAN + k] = crc[8 * k +: 8];
   endfunction

   task automatic send_frame(logic [31:0] len, int count);
      offer_item(CMD_START, len, rand_byte());
      for (int k = 0; k < count && k < frame.size(); k++)
         offer_item(CMD_DATA, $urandom, frame[k]);
   endtask

   task automatic test_idle_data();
      offer_item(CMD_DATA, 32'hFFFF_FFFF, 8'h00);
      offer_item(CMD_DATA, 32'h0000_0000, 8'hFF);
   endtask

   task automatic test_short_header();
      offer_item(CMD_START, 32'h0000_0000, 8'hFF);
      offer_item(CMD_START, HDR_BYTES - 1, 8'h00);
      offer_item(CMD_DATA, 32'hFFFF_FFFF, 8'h5A);
   endtask

   task automatic test_bad_magic();
      build_frame(0, 0, 1'b1);
      frame[3] = frame[3] ^ 8'h80;
      send_frame(HDR_BYTES, 6);
   endtask

   task automatic test_bad_version();
      build_frame(0, 0, 1'b1);
      frame[5] = 8'h01;
      send_frame(HDR_BYTES, 7);
      frame[4] = 8'h00;
      frame[5] = 8'h00;
      send_frame(HDR_BYTES, 6);
   endtask

   task automatic test_short_records();
      build_frame(1, 0, 1'b1);
      send_frame(HDR_BYTES + REC_BYTES - 1, 12);
      // all-ones count against all-ones length: only a wide product catches it
      for (int k = 8; k < 12; k++) frame[k] = 8'hFF;
      send_frame(32'hFFFF_FFFF, 12);
   endtask

   task automatic test_restart();
      build_frame(0, 0, 1'b1);
      send_frame(32'hFFFF_FFFF, 20);
      send_frame(HDR_BYTES, HDR_BYTES);
   endtask

   task automatic test_full_payloads();
      build_frame(1, 0, 1'b1);
      send_frame(frame.size(), frame.size());
      build_frame(2, 3, 1'b0);
      send_frame(frame.size(), frame.size());
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int first;
      int pick;
      int records;
      int trail;
      int len;
      first = decoded_items;
      while (decoded_items - first < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 9) < 3) records = 0;
            else if ($urandom_range(0, 9) < 8) records = $urandom_range(1, 2);
            else records = $urandom_range(3, 5);
            trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            build_frame(records, trail, $urandom_range(0, 6) != 0);
            len = frame.size();
            case ($urandom_range(0, 9))
               0:       send_frame(len + $urandom_range(1, 30), len);
               1:       send_frame(len, $urandom_range(1, len - 1));
               default: send_frame(len, len);
            endcase
         end else if (pick < 80) begin
            build_frame($urandom_range(1, 3), 0, 1'b1);
            len = frame.size();
            case ($urandom_range(0, 2))
               0: frame[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
               1: frame[$urandom_range(4, 5)] ^= 8'($urandom_range(1, 255));
               default: len = len - $urandom_range(1, REC_BYTES);
            endcase
            send_frame(len, frame.size());
         end else if (pick < 88) begin
            offer_item(CMD_START, $urandom_range(0, HDR_BYTES - 1), rand_byte());
            repeat ($urandom_range(0, 3)) offer_item(CMD_DATA, $urandom, rand_byte());
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 4)) offer_item(CMD_DATA, $urandom, rand_byte());
         end else begin
            offer_item(CMD_START, $urandom, rand_byte());
            repeat ($urandom_range(0, 10)) offer_item(CMD_DATA, $urandom, rand_byte());
         end
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
   endtask

   initial begin
      req_chan.valid          <= 1'b0;
      req_chan.command        <= CMD_DATA;
      req_chan.payload_length <= '0;
      req_chan.data_byte      <= '0;
      clear_decoder();
      burst_left         = 0;
      request_count      = 0;
      decoded_items      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_data();
      test_short_header();
      test_bad_magic();
      test_bad_version();
      test_short_records();
      test_restart();
      test_full_payloads();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         note_mismatch("results never delivered", pending_results.size(), '0);
      $display("Run: %0d request transfers (%0d decoded), %0d result transfers checked.",
               request_count, decoded_items, result_count);
      $display("Payload ends: %0d ok with CRC agreement, %0d ok with CRC disagreement, %0d errors.",
               ok_crc_match, ok_crc_miss, error_status_count);
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
